>>> design/rtcp_delay_level_estimator_top_assert.svh
// Assertion macros for the RTCP delay level estimator.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef RTCP_DELAY_LEVEL_ESTIMATOR_TOP_ASSERT_SVH
`define RTCP_DELAY_LEVEL_ESTIMATOR_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define RTCPDL_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RTCPDL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rtcpdl_pkg.sv
// Shared types and constants of the RTCP delay level estimator.
// Used by rtcpdl_level and rtcp_delay_level_estimator_top; depends on nothing.
`default_nettype none

package rtcpdl_pkg;

	// Default widths of the running delay sum and report count
	localparam int DEF_SUM_WIDTH   = 56;
	localparam int DEF_COUNT_WIDTH = 24;

	// Register reset values, 1/65536 s units
	localparam logic [31:0] IDLE_THR_RST = 32'd3277;
	localparam logic [31:0] BUSY_THR_RST = 32'd13107;
	localparam logic [31:0] GAP_PEN_RST  = 32'd32768;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_IDLE_THR = 2'd0,
		CFG_BUSY_THR = 2'd1,
		CFG_GAP_PEN  = 2'd2
	} cfg_index_t;

	// Network level codes
	typedef enum logic [1:0] {
		LVL_UNKNOWN = 2'd0,
		LVL_IDLE    = 2'd1,
		LVL_NORMAL  = 2'd2,
		LVL_BUSY    = 2'd3
	} net_level_t;

	// Top-level sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DELAY,
		ST_SEQ,
		ST_JUDGE,
		ST_ADD,
		ST_UPD,
		ST_LSTART,
		ST_LWAIT,
		ST_DONE
	} state_t;

	// Level unit states
	typedef enum logic [1:0] {
		LV_IDLE,
		LV_MUL,
		LV_CMP
	} lv_state_t;

	// Level unit status back to the sequencer
	typedef struct packed {
		logic       done;
		net_level_t level;
	} lvl_stat_t;

endpackage

`default_nettype wire

>>> design/rtcp_delay_level_estimator_top.sv
// RTCP one-way delay level estimator, top level.
// Depends on rtcpdl_pkg, rtcpdl_level and rtcp_delay_level_estimator_top_assert.svh.
//
// Usage:
//   The s_ channel takes one request per report block or clear command; the m_
//   channel returns exactly one result per request. The user must write the registers
//   through cfg_we/cfg_index/cfg_data only while no request is in flight; the block
//   does not enforce this. The first nonzero source locks the estimator; reports of
//   other sources are answered as not accepted and leave the state alone.
// Sequencing:
//   One request at a time. A report runs the delay, loss check and sum update steps
//   before the level check; a clear or refused report goes straight to the level check.
//   When the running sum is empty the multiply is skipped. A new request is taken only
//   after the previous result has been posted to the output register. The work is set by
//   the 8-step loss check loop and the one-bit-a-cycle threshold multiply.
// Reset:
//   arst_n clears the lock, counters, running sum and count, and loads the default
//   thresholds and gap penalty.
// Stall:
//   A finished result sits in the output register while m_tready is low; the next
//   request is accepted and worked on meanwhile, and waits before its result only
//   if the previous one has still not been taken.
`default_nettype none

module rtcp_delay_level_estimator_top #(
	parameter int SUM_WIDTH   = rtcpdl_pkg::DEF_SUM_WIDTH,
	parameter int COUNT_WIDTH = rtcpdl_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Report input
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// source_id[31:0], loss_fraction[39:32], cumulative_lost[63:40],
	// highest_seq[95:64], last_sr_stamp[127:96], delay_since_sr[159:128],
	// arrival_stamp[191:160]
	input  wire logic [191:0] s_tdata,
	// action[0]
	input  wire logic [0:0]   s_tuser,
	// Result output
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// accepted[0], sample_delay[31:1], in_sequence[32], loss_seen[33],
	// net_level[35:34], zero[39:36]
	output logic [39:0]       m_tdata,
	// Configuration write port
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	rtcpdl_pkg::state_t state_q, state_d;

	// Registers
	logic [31:0] idle_thr_q, busy_thr_q, gap_pen_q;

	// Persistent estimator state
	logic [31:0]            locked_q;
	logic [7:0]             last_frac_q;
	logic [23:0]            last_lost_q;
	logic [31:0]            last_seq_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// Captured request
	logic        act_q;
	logic [31:0] src_q, seq_q, lsr_q, dlsr_q, arr_q;
	logic [7:0]  frac_q;
	logic [23:0] lost_q;

	// Working registers
	logic        acc_q, inseq_q;
	logic [30:0] delay_q;
	logic [24:0] ld_q;
	logic [31:0] sd_q;
	logic [33:0] dif_q;
	logic [41:0] rem_q, mc_q;
	logic [7:0]  fr_q;
	logic [2:0]  step_q;
	logic [32:0] add_q;

	// Result register
	logic                   out_valid_q;
	logic                   out_acc_q, out_inseq_q, out_loss_q;
	logic [30:0]            out_delay_q;
	rtcpdl_pkg::net_level_t out_level_q;

	logic                   match, out_free, lvl_start;
	logic [33:0]            dif2;
	logic [SUM_WIDTH:0]     nsum;
	logic [COUNT_WIDTH:0]   ncnt;
	rtcpdl_pkg::lvl_stat_t  lvl_stat;

	assign match     = (locked_q == '0) || (locked_q == src_q);
	assign out_free  = !out_valid_q || m_tready;
	assign lvl_start = (state_q == rtcpdl_pkg::ST_LSTART);
	assign dif2      = dif_q - {2'b00, dlsr_q};
	assign nsum      = {1'b0, sum_q} + (SUM_WIDTH + 1)'(add_q);
	assign ncnt      = {1'b0, cnt_q} + (COUNT_WIDTH + 1)'(inseq_q ? 2'd1 : 2'd2);

	assign s_tready = (state_q == rtcpdl_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_level_q, out_loss_q, out_inseq_q, out_delay_q, out_acc_q};

	rtcpdl_level #(
		.SUM_WIDTH   (SUM_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lvl_start),
		.sum      (sum_q),
		.count    (cnt_q),
		.idle_thr (idle_thr_q),
		.busy_thr (busy_thr_q),
		.stat     (lvl_stat)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtcpdl_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = rtcpdl_pkg::ST_CHECK;
			end
			rtcpdl_pkg::ST_CHECK: begin
				if (act_q || !match) state_d = rtcpdl_pkg::ST_LSTART;
				else state_d = rtcpdl_pkg::ST_DELAY;
			end
			rtcpdl_pkg::ST_DELAY: state_d = rtcpdl_pkg::ST_SEQ;
			rtcpdl_pkg::ST_SEQ: begin
				if (step_q == '0) state_d = rtcpdl_pkg::ST_JUDGE;
			end
			rtcpdl_pkg::ST_JUDGE: state_d = rtcpdl_pkg::ST_ADD;
			rtcpdl_pkg::ST_ADD: state_d = rtcpdl_pkg::ST_UPD;
			rtcpdl_pkg::ST_UPD: state_d = rtcpdl_pkg::ST_LSTART;
			rtcpdl_pkg::ST_LSTART: state_d = rtcpdl_pkg::ST_LWAIT;
			rtcpdl_pkg::ST_LWAIT: begin
				if (lvl_stat.done) state_d = rtcpdl_pkg::ST_DONE;
			end
			rtcpdl_pkg::ST_DONE: begin
				if (out_free) state_d = rtcpdl_pkg::ST_IDLE;
			end
			default: state_d = rtcpdl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtcpdl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_thr_q <= rtcpdl_pkg::IDLE_THR_RST;
			busy_thr_q <= rtcpdl_pkg::BUSY_THR_RST;
			gap_pen_q  <= rtcpdl_pkg::GAP_PEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtcpdl_pkg::CFG_IDLE_THR: idle_thr_q <= cfg_data;
				rtcpdl_pkg::CFG_BUSY_THR: busy_thr_q <= cfg_data;
				rtcpdl_pkg::CFG_GAP_PEN:  gap_pen_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lock, counter history, running sum and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q    <= '0;
			last_frac_q <= '0;
			last_lost_q <= '0;
			last_seq_q  <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
		end else if (state_q == rtcpdl_pkg::ST_CHECK) begin
			if (act_q) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				if (locked_q == '0) locked_q <= src_q;
				if (match) begin
					last_frac_q <= frac_q;
					last_lost_q <= lost_q;
					last_seq_q  <= seq_q;
				end
			end
		end else if (state_q == rtcpdl_pkg::ST_UPD && delay_q != '0) begin
			// Saturate both at their maximum
			sum_q <= nsum[SUM_WIDTH] ? '1 : nsum[SUM_WIDTH-1:0];
			cnt_q <= ncnt[COUNT_WIDTH] ? '1 : ncnt[COUNT_WIDTH-1:0];
		end
	end

	// Capture the request and run the delay and loss check datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rtcpdl_pkg::ST_IDLE: begin
				act_q  <= s_tuser[0];
				src_q  <= s_tdata[31:0];
				frac_q <= s_tdata[39:32];
				lost_q <= s_tdata[63:40];
				seq_q  <= s_tdata[95:64];
				lsr_q  <= s_tdata[127:96];
				dlsr_q <= s_tdata[159:128];
				arr_q  <= s_tdata[191:160];
			end
			rtcpdl_pkg::ST_CHECK: begin
				acc_q   <= !act_q && match;
				delay_q <= '0;
				inseq_q <= 1'b0;
				ld_q    <= {lost_q[23], lost_q} - {last_lost_q[23], last_lost_q};
				sd_q    <= seq_q - last_seq_q;
				dif_q   <= {2'b00, arr_q} - {2'b00, lsr_q};
			end
			rtcpdl_pkg::ST_DELAY: begin
				// Halve a positive difference; drop it when LSR or DLSR is zero
				delay_q <= (lsr_q != '0 && dlsr_q != '0 && !dif2[33]) ? dif2[31:1] : '0;
				rem_q   <= {10'b0, ld_q[23:0], 8'b0};
				mc_q    <= {10'b0, sd_q};
				fr_q    <= frac_q;
				step_q  <= 3'd7;
			end
			rtcpdl_pkg::ST_SEQ: begin
				// Subtract fraction * seq delta, one fraction bit a cycle
				if (fr_q[0]) rem_q <= rem_q - mc_q;
				mc_q   <= mc_q << 1;
				fr_q   <= fr_q >> 1;
				step_q <= step_q - 1'b1;
			end
			rtcpdl_pkg::ST_JUDGE: begin
				// In sequence when the fraction is zero or 0 <= 256*lost delta - frac*seq delta < seq delta
				inseq_q <= (frac_q == '0) ||
					(sd_q != '0 && !ld_q[24] && !rem_q[41] && rem_q < {10'b0, sd_q});
			end
			rtcpdl_pkg::ST_ADD: begin
				add_q <= {2'b00, delay_q} + (inseq_q ? 33'd0 : {1'b0, gap_pen_q});
			end
			default: ;
		endcase
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rtcpdl_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtcpdl_pkg::ST_DONE && out_free) begin
			out_acc_q   <= acc_q;
			out_delay_q <= delay_q;
			out_inseq_q <= inseq_q;
			out_loss_q  <= (last_frac_q != '0);
			out_level_q <= lvl_stat.level;
		end
	end

`include "rtcp_delay_level_estimator_top_assert.svh"

	`RTCPDL_ASSERT_NEXT(a_lock_holds, locked_q != '0, locked_q == $past(locked_q), "locked source changed")
	`RTCPDL_ASSERT_IMPLY(a_sum_count_pair, 1'b1, (sum_q == '0) == (cnt_q == '0), "sum and count disagree on empty")
	`RTCPDL_ASSERT_IMPLY(a_done_in_wait, lvl_stat.done, state_q == rtcpdl_pkg::ST_LWAIT, "level done while not waiting")
	`RTCPDL_ASSERT_IMPLY(a_refused_empty, out_valid_q && !out_acc_q, !out_inseq_q && out_delay_q == '0, "refused result carries data")

endmodule

`default_nettype wire

>>> design/rtcpdl_level.sv
// Level classifier: compares sum against threshold*count with a bit-serial multiply.
// Depends on rtcpdl_pkg.
`default_nettype none

module rtcpdl_level #(
	parameter int SUM_WIDTH   = rtcpdl_pkg::DEF_SUM_WIDTH,
	parameter int COUNT_WIDTH = rtcpdl_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SUM_WIDTH-1:0]   sum,
	input  wire logic [COUNT_WIDTH-1:0] count,
	input  wire logic [31:0]            idle_thr,
	input  wire logic [31:0]            busy_thr,
	output rtcpdl_pkg::lvl_stat_t       stat
);

	localparam int PW   = 32 + COUNT_WIDTH;
	localparam int CMPW = (PW > SUM_WIDTH) ? PW : SUM_WIDTH;
	localparam int BW   = $clog2(COUNT_WIDTH);

	rtcpdl_pkg::lv_state_t state_q, state_d;
	rtcpdl_pkg::lvl_stat_t stat_q;

	logic [PW-1:0]          acc_idle_q, acc_busy_q;
	logic [PW-1:0]          mc_idle_q, mc_busy_q;
	logic [COUNT_WIDTH-1:0] mlt_q;
	logic [BW-1:0]          bit_q;
	logic                   empty;
	logic [CMPW-1:0]        sum_ext, prod_idle, prod_busy;

	assign empty     = (sum == '0) || (count == '0);
	assign sum_ext   = CMPW'(sum);
	assign prod_idle = CMPW'(acc_idle_q);
	assign prod_busy = CMPW'(acc_busy_q);
	assign stat      = stat_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtcpdl_pkg::LV_IDLE: begin
				if (start && !empty) state_d = rtcpdl_pkg::LV_MUL;
			end
			rtcpdl_pkg::LV_MUL: begin
				if (bit_q == '0) state_d = rtcpdl_pkg::LV_CMP;
			end
			rtcpdl_pkg::LV_CMP: state_d = rtcpdl_pkg::LV_IDLE;
			default: state_d = rtcpdl_pkg::LV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtcpdl_pkg::LV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Report the level; an empty average is unknown right away
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '{done: 1'b0, level: rtcpdl_pkg::LVL_UNKNOWN};
		end else begin
			stat_q.done <= 1'b0;
			if (state_q == rtcpdl_pkg::LV_IDLE && start && empty) begin
				stat_q.done  <= 1'b1;
				stat_q.level <= rtcpdl_pkg::LVL_UNKNOWN;
			end else if (state_q == rtcpdl_pkg::LV_CMP) begin
				stat_q.done <= 1'b1;
				if (sum_ext < prod_idle) begin
					stat_q.level <= rtcpdl_pkg::LVL_IDLE;
				end else if (sum_ext > prod_busy) begin
					stat_q.level <= rtcpdl_pkg::LVL_BUSY;
				end else begin
					stat_q.level <= rtcpdl_pkg::LVL_NORMAL;
				end
			end
		end
	end

	// Shift-add both products, one count bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == rtcpdl_pkg::LV_IDLE) begin
			acc_idle_q <= '0;
			acc_busy_q <= '0;
			mc_idle_q  <= PW'(idle_thr);
			mc_busy_q  <= PW'(busy_thr);
			mlt_q      <= count;
			bit_q      <= BW'(COUNT_WIDTH - 1);
		end else if (state_q == rtcpdl_pkg::LV_MUL) begin
			if (mlt_q[0]) begin
				acc_idle_q <= acc_idle_q + mc_idle_q;
				acc_busy_q <= acc_busy_q + mc_busy_q;
			end
			mc_idle_q <= mc_idle_q << 1;
			mc_busy_q <= mc_busy_q << 1;
			mlt_q     <= mlt_q >> 1;
			bit_q     <= bit_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for rtcp_delay_level_estimator_top.
// Drives report and clear requests; compares results to bench predictions or typed rows.
// Depends on rtcpdl_pkg and the RTL of the estimator.
`timescale 1ns / 1ps

module testbench;

	localparam int SUM_W = rtcpdl_pkg::DEF_SUM_WIDTH;
	localparam int CNT_W = rtcpdl_pkg::DEF_COUNT_WIDTH;
	localparam logic [63:0] SUM_MAX = {{(64 - SUM_W){1'b0}}, {SUM_W{1'b1}}};
	localparam logic [31:0] CNT_MAX = {{(32 - CNT_W){1'b0}}, {CNT_W{1'b1}}};
	localparam logic [31:0] LOCK_SSRC = 32'h5A3C_96E1;
	localparam int DRAIN_CYCLES = 2 * (CNT_W + 17);
	localparam int SEGMENTS = 11;
	localparam int SEG_ITEMS = 150;
	localparam int HOLD_AT = 1400;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS = 22;
	localparam longint TIME_LIMIT_NS = 2_000_000;

	// Request payload in s_tdata order, lowest field last
	typedef struct packed {
		logic [31:0] arrival;
		logic [31:0] dlsr;
		logic [31:0] lsr;
		logic [31:0] seq;
		logic [23:0] lost;
		logic [7:0]  frac;
		logic [31:0] src;
	} report_t;

	// Result payload in m_tdata order
	typedef struct packed {
		logic [3:0]             pad;
		rtcpdl_pkg::net_level_t level;
		logic                   loss_seen;
		logic                   in_seq;
		logic [30:0]            delay;
		logic                   accepted;
	} result_t;

	// One row of directed stimulus; typed rows carry their expected result
	typedef struct {
		logic                   action;
		logic [31:0]            src;
		logic [7:0]             frac;
		logic [23:0]            lost;
		logic [31:0]            seq;
		logic [31:0]            lsr;
		logic [31:0]            dlsr;
		logic [31:0]            arrival;
		logic                   typed;
		logic                   acc;
		logic [30:0]            delay;
		logic                   in_seq;
		logic                   loss;
		rtcpdl_pkg::net_level_t level;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [191:0]           s_tdata;
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [39:0]            m_tdata;
	logic                   cfg_we;
	rtcpdl_pkg::cfg_index_t cfg_index;
	logic [31:0]            cfg_data;

	// Bench copy of the estimator state and registers
	logic [31:0]      thr_idle, thr_busy, penalty;
	logic [31:0]      lock_src, prev_seq;
	logic [7:0]       prev_frac;
	logic [23:0]      prev_lost;
	logic [SUM_W-1:0] delay_sum;
	logic [CNT_W-1:0] report_cnt;

	result_t     awaited_estimates [$];
	dir_row_t    directed_rows [DIR_ROWS];
	int unsigned tx_idle_pct, rx_idle_pct;
	int          results_seen;
	int          mismatches;

	rtcp_delay_level_estimator_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Classify the running average against the thresholds
	function automatic rtcpdl_pkg::net_level_t classify_average();
		logic [63:0] avg, rem;
		if (delay_sum == '0 || report_cnt == '0)
			return rtcpdl_pkg::LVL_UNKNOWN;
		avg = 64'(delay_sum) / 64'(report_cnt);
		rem = 64'(delay_sum) % 64'(report_cnt);
		if (avg < 64'(thr_idle))
			return rtcpdl_pkg::LVL_IDLE;
		if (avg > 64'(thr_busy) || (avg == 64'(thr_busy) && rem != 0))
			return rtcpdl_pkg::LVL_BUSY;
		return rtcpdl_pkg::LVL_NORMAL;
	endfunction

	// Work out the result of one request and advance the bench state
	function automatic result_t estimate_report(input logic is_clear, input report_t rep);
		result_t     res;
		longint      lost_delta, diff;
		logic [31:0] seq_delta, step;
		logic [63:0] ratio, add;
		res = '0;
		if (is_clear) begin
			delay_sum = '0;
			report_cnt = '0;
		end else begin
			if (lock_src == '0)
				lock_src = rep.src;
			if (lock_src == rep.src) begin
				res.accepted = 1'b1;
				lost_delta = longint'($signed(rep.lost)) - longint'($signed(prev_lost));
				seq_delta = rep.seq - prev_seq;
				prev_frac = rep.frac;
				prev_lost = rep.lost;
				prev_seq = rep.seq;

				// Loss fraction against the counter deltas; a zero fraction always agrees
				if (rep.frac == 8'd0) begin
					res.in_seq = 1'b1;
				end else if (seq_delta != 0 && lost_delta >= 0) begin
					ratio = (64'(lost_delta) * 64'd256) / 64'(seq_delta);
					res.in_seq = (ratio == 64'(rep.frac));
				end

				// Halve arrival - LSR - DLSR without wrap, clamp at zero
				if (rep.lsr != 0 && rep.dlsr != 0) begin
					diff = longint'({32'd0, rep.arrival}) - longint'({32'd0, rep.lsr})
						- longint'({32'd0, rep.dlsr});
					if (diff > 0)
						res.delay = 31'(diff >> 1);
				end

				// Accumulate with saturation; a gap adds the penalty and counts twice
				if (res.delay != 0) begin
					add = 64'(res.delay);
					step = 32'd1;
					if (!res.in_seq) begin
						add = add + 64'(penalty);
						step = 32'd2;
					end
					if (64'(delay_sum) > SUM_MAX - add)
						delay_sum = '1;
					else
						delay_sum = delay_sum + add[SUM_W-1:0];
					if (32'(report_cnt) > CNT_MAX - step)
						report_cnt = '1;
					else
						report_cnt = report_cnt + step[CNT_W-1:0];
				end
			end
		end
		res.loss_seen = (prev_frac != 8'd0);
		res.level = classify_average();
		return res;
	endfunction

	// Build one random request: mostly well-formed reports from the locked source
	function automatic void compose_report(output logic is_clear, output report_t rep);
		int unsigned pick, seq_step, lost_step, ratio, wait_units, span;
		pick = $urandom_range(0, 99);
		is_clear = (pick < 4);
		rep = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (pick < 12)
			return;
		rep.src = LOCK_SSRC;
		if (pick < 18) begin
			// Noise from the locked source, sometimes with an unchanged sequence
			if ($urandom_range(0, 3) == 0)
				rep.seq = prev_seq;
			return;
		end

		seq_step = $urandom_range(1, 300);
		lost_step = $urandom_range(0, seq_step);
		ratio = (lost_step * 256) / seq_step;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			rep.frac = (ratio > 255) ? 8'hFF : 8'(ratio);
		else if (pick < 75)
			rep.frac = 8'h00;
		else if (pick < 90)
			rep.frac = 8'(ratio + 1);
		rep.lost = prev_lost + 24'(lost_step);
		if ($urandom_range(0, 19) == 0)
			rep.lost = prev_lost - 24'($urandom_range(1, 5));
		rep.seq = prev_seq + seq_step;

		// Place the stamps so that the difference does not wrap
		pick = $urandom_range(0, 99);
		if (pick < 85)
			wait_units = $urandom_range(1, 30000);
		else if (pick < 95)
			wait_units = $urandom_range(1 << 20, 1 << 30);
		else
			wait_units = $urandom_range(0, 1);
		rep.dlsr = $urandom_range(1, 1 << 24);
		span = rep.dlsr + 2 * wait_units + $urandom_range(0, 1);
		rep.lsr = $urandom_range(1, 32'hFFFF_FFFF - span);
		rep.arrival = rep.lsr + span;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			rep.lsr = '0;
		else if (pick == 1)
			rep.dlsr = '0;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want, got);
		mismatches++;
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endtask

	// Offer one request, hold it until taken, then queue its expected result
	task automatic offer_request(input logic is_clear, input report_t rep,
			input logic has_typed, input result_t typed_res);
		result_t want;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = rep;
		s_tuser = is_clear;
		do @(posedge clk); while (!s_tready);
		want = estimate_report(is_clear, rep);
		if (has_typed)
			want = typed_res;
		awaited_estimates.push_back(want);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is in and the block is quiet
	task automatic settle();
		s_tvalid = 1'b0;
		while (awaited_estimates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_registers(input logic [31:0] idle_lvl, busy_lvl, penalty_lvl);
		cfg_we = 1'b1;
		cfg_index = rtcpdl_pkg::CFG_IDLE_THR;
		cfg_data = idle_lvl;
		@(negedge clk);
		cfg_index = rtcpdl_pkg::CFG_BUSY_THR;
		cfg_data = busy_lvl;
		@(negedge clk);
		cfg_index = rtcpdl_pkg::CFG_GAP_PEN;
		cfg_data = penalty_lvl;
		@(negedge clk);
		cfg_we = 1'b0;
		thr_idle = idle_lvl;
		thr_busy = busy_lvl;
		penalty = penalty_lvl;
	endtask

	// Stimulus: reset, directed rows, then random segments under changing settings
	initial begin : stimulus
		logic        is_clear;
		report_t     rep;
		result_t     typed_res;
		logic [31:0] lo, hi, pen;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = rtcpdl_pkg::CFG_IDLE_THR;
		cfg_data = '0;
		tx_idle_pct = 18;
		rx_idle_pct = 74;
		thr_idle = rtcpdl_pkg::IDLE_THR_RST;
		thr_busy = rtcpdl_pkg::BUSY_THR_RST;
		penalty = rtcpdl_pkg::GAP_PEN_RST;
		lock_src = '0;
		prev_frac = '0;
		prev_lost = '0;
		prev_seq = '0;
		delay_sum = '0;
		report_cnt = '0;

		directed_rows = '{
			// clear right after reset
			'{1'b1, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				1'b1, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// zero source is taken without locking; zero LSR
			'{1'b0, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h1234, 32'h5000_0000,
				1'b1, 1'b1, 31'd0, 1'b1, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// zero DLSR, loss fraction matches the deltas
			'{1'b0, 32'h0, 8'h80, 24'h10, 32'h20, 32'h1000, 32'h0, 32'hFFFF_FFFF,
				1'b1, 1'b1, 31'd0, 1'b1, 1'b1, rtcpdl_pkg::LVL_UNKNOWN},
			// lock, delay 5000
			'{1'b0, LOCK_SSRC, 8'h00, 24'h10, 32'h40, 32'h0001_0000, 32'h1000, 32'h0001_3710,
				1'b1, 1'b1, 31'd5000, 1'b1, 1'b0, rtcpdl_pkg::LVL_NORMAL},
			// foreign sources are refused
			'{1'b0, 32'hFFFF_FFFF, 8'hFF, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF,
				1'b1, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_NORMAL},
			'{1'b0, 32'h0, 8'h55, 24'h800000, 32'h0, 32'h10, 32'h10, 32'hFFFF,
				1'b1, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_NORMAL},
			// negative difference, fraction disagrees
			'{1'b0, LOCK_SSRC, 8'hFF, 24'h10, 32'h41, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
				1'b1, 1'b1, 31'd0, 1'b0, 1'b1, rtcpdl_pkg::LVL_NORMAL},
			// largest delay
			'{1'b0, LOCK_SSRC, 8'h00, 24'h10, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF,
				1'b1, 1'b1, 31'h7FFF_FFFE, 1'b1, 1'b0, rtcpdl_pkg::LVL_BUSY},
			'{1'b1, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				1'b1, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// gap on a zero sequence delta
			'{1'b0, LOCK_SSRC, 8'h10, 24'h10, 32'hFFFF_FFFF, 32'h0002_0000, 32'h100, 32'h0002_08D0,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// gap on a negative lost delta, sequence wraps
			'{1'b0, LOCK_SSRC, 8'h20, 24'hFFFFFF, 32'h10, 32'h0002_0000, 32'h100, 32'h0002_1870,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// lost counter extremes; delay of one unit, then one that halves to zero
			'{1'b0, LOCK_SSRC, 8'hFF, 24'h7FFFFF, 32'h30, 32'h0002_0000, 32'h100, 32'h0002_0102,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			'{1'b0, LOCK_SSRC, 8'h01, 24'h800000, 32'h50, 32'h0002_0000, 32'h100, 32'h0002_0101,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			'{1'b1, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// exact fraction, average equal to the idle threshold
			'{1'b0, LOCK_SSRC, 8'h40, 24'h800019, 32'hB4, 32'h0002_0000, 32'h100, 32'h0002_1A9A,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// fraction off by one
			'{1'b0, LOCK_SSRC, 8'h41, 24'h800032, 32'h118, 32'h0002_0000, 32'h100, 32'h0002_01C8,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			'{1'b1, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// full fraction, average equal to the busy threshold
			'{1'b0, LOCK_SSRC, 8'hFF, 24'h800131, 32'h218, 32'h0002_0000, 32'h100, 32'h0002_6766,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// average just over the busy threshold with a remainder
			'{1'b0, LOCK_SSRC, 8'h00, 24'h800131, 32'hFFFF_FFF0, 32'h0002_0000, 32'h100,
				32'h0002_6768, 1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// sequence wraps with a matching fraction
			'{1'b0, LOCK_SSRC, 8'h40, 24'h800139, 32'h10, 32'h0002_0000, 32'h100, 32'h0002_0164,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			'{1'b1, 32'h0, 8'h00, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN},
			// small delay reads as idle
			'{1'b0, LOCK_SSRC, 8'h00, 24'h800139, 32'h30, 32'h0002_0000, 32'h100, 32'h0002_0114,
				1'b0, 1'b0, 31'd0, 1'b0, 1'b0, rtcpdl_pkg::LVL_UNKNOWN}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed rows at the reset settings
		foreach (directed_rows[i]) begin
			rep.src = directed_rows[i].src;
			rep.frac = directed_rows[i].frac;
			rep.lost = directed_rows[i].lost;
			rep.seq = directed_rows[i].seq;
			rep.lsr = directed_rows[i].lsr;
			rep.dlsr = directed_rows[i].dlsr;
			rep.arrival = directed_rows[i].arrival;
			typed_res = '0;
			typed_res.accepted = directed_rows[i].acc;
			typed_res.delay = directed_rows[i].delay;
			typed_res.in_seq = directed_rows[i].in_seq;
			typed_res.loss_seen = directed_rows[i].loss;
			typed_res.level = directed_rows[i].level;
			offer_request(directed_rows[i].action, rep, directed_rows[i].typed, typed_res);
		end

		// Random segments; reprogram the registers between them while idle
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			if (seg < 4) begin
				tx_idle_pct = 18;
				rx_idle_pct = 74;
			end else if (seg < 8) begin
				tx_idle_pct = 74;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			pen = $urandom_range(0, 65535);
			unique case (seg % 5)
				0: begin
					lo = $urandom_range(0, 15000);
					hi = lo + $urandom_range(0, 20000);
				end
				1: begin
					lo = '0;
					hi = '1;
					pen = '1;
				end
				2: begin
					lo = '1;
					hi = '0;
					pen = '0;
				end
				3: begin
					lo = $urandom_range(5000, 30000);
					hi = $urandom_range(0, 5000);
				end
				default: begin
					lo = $urandom_range(1000, 20000);
					hi = lo;
				end
			endcase
			program_registers(lo, hi, pen);
			repeat (SEG_ITEMS) begin
				compose_report(is_clear, rep);
				offer_request(is_clear, rep, 1'b0, '0);
			end
		end
		settle();

		if (mismatches == 0)
			$display("rtcp_delay_level_estimator_top regression: pass");
		else
			$display("rtcp_delay_level_estimator_top regression: fail");
		$finish;
	end

	// Result side: random backpressure plus one long hold-off to fill the block
	initial begin : result_ready
		int hold_left;
		bit held;
		m_tready = 1'b0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			results_seen++;
			if (awaited_estimates.size() == 0) begin
				note_mismatch("unexpected result", 64'd0, 64'(m_tdata));
			end else begin
				want = awaited_estimates.pop_front();
				if (got.accepted !== want.accepted)
					note_mismatch("accepted", 64'(want.accepted), 64'(got.accepted));
				if (got.delay !== want.delay)
					note_mismatch("sample_delay", 64'(want.delay), 64'(got.delay));
				if (got.in_seq !== want.in_seq)
					note_mismatch("in_sequence", 64'(want.in_seq), 64'(got.in_seq));
				if (got.loss_seen !== want.loss_seen)
					note_mismatch("loss_seen", 64'(want.loss_seen), 64'(got.loss_seen));
				if (got.level !== want.level)
					note_mismatch("net_level", 64'(want.level), 64'(got.level));
			end
		end
	end

	initial begin : watchdog
		results_seen = 0;
		mismatches = 0;
		#(TIME_LIMIT_NS);
		$display("rtcp_delay_level_estimator_top regression: fail");
		$finish;
	end

endmodule
